// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue: default sizes,
// opcodes, result status codes and the command that every cell receives.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Default sizes
    localparam int SPQ_QUEUE_DEPTH    = 16;
    localparam int SPQ_PRIORITY_WIDTH = 16;
    localparam int SPQ_PAYLOAD_WIDTH  = 32;
    localparam int SPQ_STATUS_WIDTH   = 2;

    // Operation carried by an input item
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    // Result status
    typedef enum logic [SPQ_STATUS_WIDTH-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    // Command broadcast along the row of cells
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_cmd;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row. Holds a priority and a payload, compares its
// priority against an incoming entry, and on each command keeps its entry,
// takes the new entry, or takes its left or right neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PRIORITY_WIDTH = spq_pkg::SPQ_PRIORITY_WIDTH
) (
    input  logic                                     i_clk,
    input  spq_pkg::t_cell_cmd                       i_cmd,
    input  logic                                     i_occupied,
    input  logic signed [PRIORITY_WIDTH-1:0]         i_new_prio,
    input  logic [spq_pkg::SPQ_PAYLOAD_WIDTH-1:0]    i_new_payload,
    input  logic                                     i_left_keep,
    input  logic signed [PRIORITY_WIDTH-1:0]         i_left_prio,
    input  logic [spq_pkg::SPQ_PAYLOAD_WIDTH-1:0]    i_left_payload,
    input  logic signed [PRIORITY_WIDTH-1:0]         i_right_prio,
    input  logic [spq_pkg::SPQ_PAYLOAD_WIDTH-1:0]    i_right_payload,
    output logic                                     o_keep,
    output logic signed [PRIORITY_WIDTH-1:0]         o_prio,
    output logic [spq_pkg::SPQ_PAYLOAD_WIDTH-1:0]    o_payload,
    output logic signed [PRIORITY_WIDTH-1:0]         o_next_prio,
    output logic [spq_pkg::SPQ_PAYLOAD_WIDTH-1:0]    o_next_payload
);
    import spq_pkg::*;

    logic signed [PRIORITY_WIDTH-1:0]    r_prio;
    logic signed [PRIORITY_WIDTH-1:0]    n_prio;
    logic [SPQ_PAYLOAD_WIDTH-1:0]        r_payload;
    logic [SPQ_PAYLOAD_WIDTH-1:0]        n_payload;

    // Stay in place on a push when the stored entry outranks the new one
    assign o_keep = i_occupied && (r_prio > i_new_prio);

    // Choose the next slot contents
    always_comb begin
        n_prio    = r_prio;
        n_payload = r_payload;
        if (i_cmd.pop) begin
            n_prio    = i_right_prio;
            n_payload = i_right_payload;
        end else if (i_cmd.push && !o_keep) begin
            if (i_left_keep) begin
                n_prio    = i_new_prio;
                n_payload = i_new_payload;
            end else begin
                n_prio    = i_left_prio;
                n_payload = i_left_payload;
            end
        end
    end

    // Slot storage, no reset
    always_ff @(posedge i_clk) begin
        r_prio    <= n_prio;
        r_payload <= n_payload;
    end

    assign o_prio         = r_prio;
    assign o_payload      = r_payload;
    assign o_next_prio    = n_prio;
    assign o_next_payload = n_payload;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue kept as a row of cells sorted by descending signed
// priority. Push inserts in front of the first entry of lower or equal
// priority; pop removes the head. Every item gives one result reporting the
// head, an empty flag and the entry count.
//
//   channel | direction | handshake                  | fields
//   --------+-----------+----------------------------+-------------------------
//   in      | to block  | i_in_valid / o_in_stall    | opcode, priority_req,
//           |           |                            | payload
//   out     | from block| o_out_valid / i_out_stall  | status, head_priority,
//           |           |                            | head_payload,
//           |           |                            | is_empty_flag, entry_count
//
// One item per cycle while o_in_stall is low: every cell compares and shifts
// in parallel; the result goes to the output register, or to the skid entry
// when that one holds an untaken result. Reset (synchronous, active low)
// empties the queue and the output side and needs no clearing pass.
// A two-entry output buffer lets one more item in while a result is held;
// o_in_stall rises only once both entries hold results.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int QUEUE_DEPTH    = spq_pkg::SPQ_QUEUE_DEPTH,
    parameter int PRIORITY_WIDTH = spq_pkg::SPQ_PRIORITY_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_opcode,
    input  logic signed [PRIORITY_WIDTH-1:0]       i_priority_req,
    input  logic [spq_pkg::SPQ_PAYLOAD_WIDTH-1:0]  i_payload,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [spq_pkg::SPQ_STATUS_WIDTH-1:0]   o_status,
    output logic signed [PRIORITY_WIDTH-1:0]       o_head_priority,
    output logic [spq_pkg::SPQ_PAYLOAD_WIDTH-1:0]  o_head_payload,
    output logic                                   o_is_empty_flag,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       o_entry_count
);
    import spq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = SPQ_STATUS_WIDTH + PRIORITY_WIDTH + SPQ_PAYLOAD_WIDTH + 1 + CW;

    // Control
    logic              accept;
    logic              out_take;
    logic              is_full;
    logic              no_entries;
    t_cell_cmd         cmd;
    t_status           res_status;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    // Cell row links
    logic                                  cell_keep    [QUEUE_DEPTH];
    logic signed [PRIORITY_WIDTH-1:0]      cell_prio    [QUEUE_DEPTH];
    logic [SPQ_PAYLOAD_WIDTH-1:0]          cell_payload [QUEUE_DEPTH];
    logic signed [PRIORITY_WIDTH-1:0]      cell_nprio   [QUEUE_DEPTH];
    logic [SPQ_PAYLOAD_WIDTH-1:0]          cell_npay    [QUEUE_DEPTH];

    // Result and output buffer
    logic signed [PRIORITY_WIDTH-1:0]      res_prio;
    logic [SPQ_PAYLOAD_WIDTH-1:0]          res_payload;
    logic [RW-1:0]                         res_bus;
    logic [RW-1:0]                         r_out_bus;
    logic [RW-1:0]                         r_skid_bus;
    logic                                  r_out_valid;
    logic                                  r_skid_valid;

    // Handshake
    assign accept     = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;
    assign is_full    = (r_count == CW'(QUEUE_DEPTH));
    assign no_entries = (r_count == '0);

    // Decode the item into a row command and a status
    always_comb begin
        cmd        = '0;
        res_status = ST_OK;
        n_count    = r_count;
        if (accept) begin
            unique case (t_opcode'(i_opcode))
                OP_PUSH: begin
                    if (is_full) begin
                        res_status = ST_PUSH_FULL;
                    end else begin
                        cmd.push = 1'b1;
                        n_count  = r_count + CW'(1);
                    end
                end
                OP_POP: begin
                    if (no_entries) begin
                        res_status = ST_POP_EMPTY;
                    end else begin
                        cmd.pop = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Row of cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                              left_keep;
        logic signed [PRIORITY_WIDTH-1:0]  left_prio;
        logic [SPQ_PAYLOAD_WIDTH-1:0]      left_payload;
        logic signed [PRIORITY_WIDTH-1:0]  right_prio;
        logic [SPQ_PAYLOAD_WIDTH-1:0]      right_payload;

        if (g == 0) begin : g_head
            assign left_keep    = 1'b1;
            assign left_prio    = i_priority_req;
            assign left_payload = i_payload;
        end else begin : g_body
            assign left_keep    = cell_keep[g-1];
            assign left_prio    = cell_prio[g-1];
            assign left_payload = cell_payload[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_prio    = '0;
            assign right_payload = '0;
        end else begin : g_mid
            assign right_prio    = cell_prio[g+1];
            assign right_payload = cell_payload[g+1];
        end

        spq_cell #(
            .PRIORITY_WIDTH (PRIORITY_WIDTH)
        ) u_cell (
            .i_clk           (i_clk),
            .i_cmd           (cmd),
            .i_occupied      (r_count > CW'(g)),
            .i_new_prio      (i_priority_req),
            .i_new_payload   (i_payload),
            .i_left_keep     (left_keep),
            .i_left_prio     (left_prio),
            .i_left_payload  (left_payload),
            .i_right_prio    (right_prio),
            .i_right_payload (right_payload),
            .o_keep          (cell_keep[g]),
            .o_prio          (cell_prio[g]),
            .o_payload       (cell_payload[g]),
            .o_next_prio     (cell_nprio[g]),
            .o_next_payload  (cell_npay[g])
        );
    end

    // Head after the operation, zero when empty
    assign res_prio    = (n_count == '0) ? '0 : cell_nprio[0];
    assign res_payload = (n_count == '0) ? '0 : cell_npay[0];
    assign res_bus     = {res_status, res_prio, res_payload, (n_count == '0), n_count};

    // Output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                r_out_valid  <= r_skid_valid || accept;
                r_skid_valid <= 1'b0;
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Output buffer data
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out_bus <= r_skid_valid ? r_skid_bus : res_bus;
        end else if (accept) begin
            r_skid_bus <= res_bus;
        end
    end

    // Drive ports
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign {o_status, o_head_priority, o_head_payload, o_is_empty_flag, o_entry_count} =
        r_out_bus;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond depth");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the queue");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty_flag == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_PUSH_FULL)) |-> (o_entry_count == CW'(QUEUE_DEPTH)))
        else $error("push dropped while not full");

endmodule

// ===== tb/sorted_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue. A short directed table
// covers pops on an empty queue, priority extremes, ties (newest served first)
// and pushes into a full queue. Random segments follow that fill, churn and
// drain the queue. Every item is run through a behavioural copy of the queue
// and each result is checked in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH   = SPQ_QUEUE_DEPTH;
    localparam int PW      = SPQ_PRIORITY_WIDTH;
    localparam int DW      = SPQ_PAYLOAD_WIDTH;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int N_ROWS  = 25;
    localparam int N_SEGS  = 13;
    localparam int SEG_LEN = 48;

    // Head report returned for every item
    typedef struct packed {
        t_status               status;
        logic signed [PW-1:0]  head_prio;
        logic [DW-1:0]         head_pay;
        logic                  empty;
        logic [CW-1:0]         count;
    } t_head_report;

    // One row of the directed table; want is used only when typed is set
    typedef struct packed {
        t_opcode               op;
        logic signed [PW-1:0]  prio;
        logic [DW-1:0]         pay;
        logic                  typed;
        t_head_report          want;
    } t_dir_row;

    localparam t_head_report NO_REPORT = '0;
    localparam t_head_report EMPTY_POP = '{ST_POP_EMPTY, '0, '0, 1'b1, '0};

    localparam t_dir_row DIR_TABLE [N_ROWS] = '{
        '{OP_POP,  16'sh0000, 32'h0000_0000, 1'b1, EMPTY_POP},
        '{OP_POP,  -16'sd1,   32'hFFFF_FFFF, 1'b1, EMPTY_POP},
        '{OP_PUSH, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1,
            '{ST_OK, 16'sh7FFF, 32'hFFFF_FFFF, 1'b0, 5'd1}},
        '{OP_PUSH, 16'sh8000, 32'h0000_0000, 1'b1,
            '{ST_OK, 16'sh7FFF, 32'hFFFF_FFFF, 1'b0, 5'd2}},
        '{OP_PUSH, 16'sd0,    32'hA5A5_A5A5, 1'b0, NO_REPORT},
        '{OP_PUSH, -16'sd1,   32'h5A5A_5A5A, 1'b0, NO_REPORT},
        '{OP_PUSH, 16'sd1,    32'h0000_0001, 1'b0, NO_REPORT},
        '{OP_PUSH, 16'sh7FFF, 32'h1234_5678, 1'b1,
            '{ST_OK, 16'sh7FFF, 32'h1234_5678, 1'b0, 5'd6}},
        '{OP_POP,  16'sd0,    32'h0000_0000, 1'b1,
            '{ST_OK, 16'sh7FFF, 32'hFFFF_FFFF, 1'b0, 5'd5}},
        '{OP_PUSH, 16'sh8000, 32'h8000_0000, 1'b0, NO_REPORT},
        '{OP_PUSH, 16'sd0,    32'h0000_FFFF, 1'b0, NO_REPORT},
        '{OP_PUSH, 16'sd2,    32'h0000_0002, 1'b0, NO_REPORT},
        '{OP_PUSH, -16'sd2,   32'hFFFF_0000, 1'b0, NO_REPORT},
        '{OP_PUSH, 16'sd100,  32'h0F0F_0F0F, 1'b0, NO_REPORT},
        '{OP_PUSH, -16'sd100, 32'hF0F0_F0F0, 1'b0, NO_REPORT},
        '{OP_PUSH, 16'sh4000, 32'h3333_3333, 1'b0, NO_REPORT},
        '{OP_PUSH, 16'shC000, 32'hCCCC_CCCC, 1'b0, NO_REPORT},
        '{OP_PUSH, 16'sd3,    32'h0000_0003, 1'b0, NO_REPORT},
        '{OP_PUSH, 16'sh7FFE, 32'h7FFF_FFFE, 1'b0, NO_REPORT},
        '{OP_PUSH, 16'sh8001, 32'h8000_0001, 1'b0, NO_REPORT},
        '{OP_PUSH, 16'sh7FFF, 32'hDEAD_BEEF, 1'b1,
            '{ST_PUSH_FULL, 16'sh7FFF, 32'hFFFF_FFFF, 1'b0, 5'd16}},
        '{OP_PUSH, 16'sh8000, 32'hCAFE_F00D, 1'b1,
            '{ST_PUSH_FULL, 16'sh7FFF, 32'hFFFF_FFFF, 1'b0, 5'd16}},
        '{OP_POP,  16'sd5,    32'h1111_1111, 1'b0, NO_REPORT},
        '{OP_POP,  16'sd0,    32'h0000_0000, 1'b0, NO_REPORT},
        '{OP_POP,  -16'sd7,   32'h2222_2222, 1'b0, NO_REPORT}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_opcode;
    logic signed [PW-1:0]  i_priority_req;
    logic [DW-1:0]         i_payload;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [SPQ_STATUS_WIDTH-1:0] o_status;
    logic signed [PW-1:0]  o_head_priority;
    logic [DW-1:0]         o_head_payload;
    logic                  o_is_empty_flag;
    logic [CW-1:0]         o_entry_count;

    // Behavioural copy of the queue, slot 0 is the head
    logic signed [PW-1:0]  held_prio [DEPTH];
    logic [DW-1:0]         held_pay  [DEPTH];
    int                    held_count;

    t_head_report          expected_heads [$];

    // Typed expectation for the item currently on the input channel
    logic                  row_typed;
    t_head_report          row_want;

    bit                    in_idle_on;
    bit                    out_idle_on;

    int mismatches   = 0;
    int items_taken  = 0;
    int heads_seen   = 0;
    int full_drops   = 0;
    int empty_pops   = 0;

    sorted_priority_queue uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_priority_req  (i_priority_req),
        .i_payload       (i_payload),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_head_priority (o_head_priority),
        .o_head_payload  (o_head_payload),
        .o_is_empty_flag (o_is_empty_flag),
        .o_entry_count   (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // Apply one operation to the copy of the queue and report the new head
    task automatic apply_to_queue(input t_opcode op, input logic signed [PW-1:0] prio,
                                  input logic [DW-1:0] pay, output t_head_report rep);
        int pos;
        int k;
        rep.status = ST_OK;
        if (op == OP_PUSH) begin
            if (held_count >= DEPTH) begin
                rep.status = ST_PUSH_FULL;
            end else begin
                // insert in front of the first entry of lower or equal priority
                pos = 0;
                while (pos < held_count && held_prio[pos] > prio) pos++;
                for (k = held_count; k > pos; k--) begin
                    held_prio[k] = held_prio[k-1];
                    held_pay[k]  = held_pay[k-1];
                end
                held_prio[pos] = prio;
                held_pay[pos]  = pay;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                rep.status = ST_POP_EMPTY;
            end else begin
                for (k = 1; k < held_count; k++) begin
                    held_prio[k-1] = held_prio[k];
                    held_pay[k-1]  = held_pay[k];
                end
                held_count--;
            end
        end
        rep.empty     = (held_count == 0);
        rep.head_prio = rep.empty ? '0 : held_prio[0];
        rep.head_pay  = rep.empty ? '0 : held_pay[0];
        rep.count     = CW'(held_count);
    endtask

    // Compare one result with the oldest expectation
    task automatic check_head(input t_head_report got, input t_head_report want);
        if (got.status !== want.status || got.head_prio !== want.head_prio ||
            got.head_pay !== want.head_pay || got.empty !== want.empty ||
            got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: mismatch status %0d/%0d prio %0d/%0d payload %h/%h",
                         $realtime, got.status, want.status, got.head_prio,
                         want.head_prio, got.head_pay, want.head_pay);
                $display("    empty %b/%b count %0d/%0d (got/expected)",
                         got.empty, want.empty, got.count, want.count);
            end
        end
    endtask

    // Present one item after a random gap and hold it until accepted
    task automatic send_item(input t_opcode op, input logic signed [PW-1:0] prio,
                             input logic [DW-1:0] pay, input logic typed,
                             input t_head_report want);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_priority_req <= prio;
        i_payload      <= pay;
        row_typed       = typed;
        row_want        = want;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Predict on acceptance, check on delivery
    always @(posedge i_clk) begin : watch_channels
        t_head_report predicted;
        t_head_report seen;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                apply_to_queue(t_opcode'(i_opcode), i_priority_req, i_payload, predicted);
                items_taken++;
                if (predicted.status == ST_PUSH_FULL) full_drops++;
                if (predicted.status == ST_POP_EMPTY) empty_pops++;
                expected_heads.push_back(row_typed ? row_want : predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                seen.status    = t_status'(o_status);
                seen.head_prio = o_head_priority;
                seen.head_pay  = o_head_payload;
                seen.empty     = o_is_empty_flag;
                seen.count     = o_entry_count;
                heads_seen++;
                if (expected_heads.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected", $realtime);
                end else begin
                    check_head(seen, expected_heads.pop_front());
                end
            end
        end
    end

    // Receiver: before each result, stall at random when output idling is on
    initial begin : drain_results
        int hold;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hold = out_idle_on ? $urandom_range(0, 17) : 0;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Main stimulus
    initial begin : drive_items
        int seg;
        int n;
        int push_pct;
        int pick;
        int val;
        t_opcode op;
        logic signed [PW-1:0] prio;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_PUSH;
        i_priority_req = '0;
        i_payload      = '0;
        row_typed      = 1'b0;
        row_want       = NO_REPORT;
        held_count     = 0;
        in_idle_on     = 1'b0;
        out_idle_on    = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        for (n = 0; n < N_ROWS; n++)
            send_item(DIR_TABLE[n].op, DIR_TABLE[n].prio, DIR_TABLE[n].pay,
                      DIR_TABLE[n].typed, DIR_TABLE[n].want);

        // Random segments alternate between filling, draining and churning
        for (seg = 0; seg < N_SEGS; seg++) begin
            in_idle_on  = (seg >= 2) && ($urandom_range(0, 3) != 0);
            out_idle_on = (seg >= 2) && ($urandom_range(0, 3) != 0);
            unique case (seg % 3)
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            for (n = 0; n < SEG_LEN; n++) begin
                op   = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                pick = $urandom_range(0, 9);
                // mostly a narrow band to force ties, sometimes anything or an extreme
                if (pick < 6) begin
                    val  = $urandom_range(0, 8) - 4;
                    prio = PW'(val);
                end else if (pick < 9) begin
                    prio = PW'($urandom);
                end else begin
                    prio = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                end
                send_item(op, prio, $urandom, 1'b0, NO_REPORT);
            end
        end
        i_in_valid <= 1'b0;

        // Let the last results through
        while (expected_heads.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d items and %0d results; %0d pushes into a full queue,",
                 items_taken, heads_seen, full_drops);
        $display("%0d pops on an empty queue, %0d mismatches.", empty_pops, mismatches);
        if (mismatches == 0 && expected_heads.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Guard against a hung handshake
    initial begin : watchdog
        #2ms;
        $display("Timeout with %0d results outstanding", expected_heads.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sorted_priority_queue.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
